[rtl/mssr_pkg.sv]
// Shared types, constants and helper functions for the mesh bypass-request fan-out.
// Used by every module of the block; depends on nothing else.
package mssr_pkg;

	// Field widths of the request and slot beats.
	localparam int ROUTER_W  = 8;
	localparam int DIM_W     = 5;
	localparam int HOP_W     = 4;
	localparam int TAG_W     = 16;
	localparam int DIR_W     = 2;
	localparam int CFG_IDX_W = 2;

	// Coordinate widths: column within -8..23, row within -8..263.
	localparam int X_W   = 6;
	localparam int Y_W   = 10;
	localparam int REM_W = 4;

	// Restoring divider: one quotient bit per cycle.
	localparam int DIV_STEPS = ROUTER_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [HOP_W-1:0] MAX_HOPS = HOP_W'(8);
	localparam logic [DIM_W-1:0] DIM_MIN  = DIM_W'(1);
	localparam logic [DIM_W-1:0] DIM_MAX  = DIM_W'(16);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MESH_COLUMNS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MESH_ROWS    = CFG_IDX_W'(1);

	typedef enum logic [DIR_W-1:0] {
		DIR_EAST  = 2'd0,
		DIR_WEST  = 2'd1,
		DIR_NORTH = 2'd2,
		DIR_SOUTH = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_LEG1,
		ST_LEG2,
		ST_NONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic leg1_start;
		logic leg2_start;
		logic emit;
		logic emit_none;
		logic last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic both_zero;
		logic h1_zero;
		logic h2_zero;
		logic leg_end;
		logic out_free;
	} sts_t;

	// The port at the receiver faces back along the direction of travel.
	function automatic dir_t opposite_dir(input dir_t d);
		dir_t r;
		case (d)
			DIR_EAST:  r = DIR_WEST;
			DIR_WEST:  r = DIR_EAST;
			DIR_NORTH: r = DIR_SOUTH;
			DIR_SOUTH: r = DIR_NORTH;
			default:   r = DIR_EAST;
		endcase
		return r;
	endfunction

	// Hop counts beyond the supported leg length saturate.
	function automatic logic [HOP_W-1:0] sat_hops(input logic [HOP_W-1:0] h);
		return (h > MAX_HOPS) ? MAX_HOPS : h;
	endfunction

	// A mesh dimension of zero acts as one, anything above sixteen as sixteen.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v < DIM_MIN) begin
			r = DIM_MIN;
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/mssr_div.sv]
// Restoring divider of a router id by the mesh column count, one bit per cycle.
// Depends on mssr_pkg.
module mssr_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              step,
	input  logic [mssr_pkg::ROUTER_W-1:0]     dividend,
	input  logic [mssr_pkg::DIM_W-1:0]        divisor,
	output logic [mssr_pkg::ROUTER_W-1:0]     quotient,
	output logic [mssr_pkg::REM_W-1:0]        remainder,
	output logic                              last
);
	import mssr_pkg::*;

	logic [ROUTER_W-1:0]  work_q;
	logic [REM_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0]     trial;
	logic [DIM_W-1:0]     diff;
	logic                 take;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, work_q[ROUTER_W-1]};
		diff  = trial - divisor;
		take  = (trial >= divisor);
	end

	// Step counter; the last step is flagged so the controller can move on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	// The quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (load) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (step) begin
			work_q <= {work_q[ROUTER_W-2:0], take};
			rem_q  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign quotient  = work_q;
	assign remainder = rem_q;
	assign last      = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

[rtl/mssr_dp.sv]
// Datapath of the fan-out: request capture, coordinate dividers, leg walk and slot register.
// Depends on mssr_pkg and mssr_div.
module mssr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mssr_pkg::cmd_t                  cmd,
	output mssr_pkg::sts_t                  sts,
	input  logic [mssr_pkg::DIM_W-1:0]      mesh_cols,
	input  logic [mssr_pkg::DIM_W-1:0]      mesh_rows,
	input  logic [mssr_pkg::ROUTER_W-1:0]   source_router,
	input  logic [mssr_pkg::ROUTER_W-1:0]   target_router_final,
	input  logic [mssr_pkg::DIR_W-1:0]      first_direction,
	input  logic [mssr_pkg::HOP_W-1:0]      first_hops,
	input  logic [mssr_pkg::HOP_W-1:0]      second_hops,
	input  logic [mssr_pkg::TAG_W-1:0]      request_tag,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [mssr_pkg::ROUTER_W-1:0]   hop_router,
	output logic [mssr_pkg::DIR_W-1:0]      arrival_port,
	output logic [mssr_pkg::HOP_W-1:0]      hop_distance,
	output logic                            bypass_request,
	output logic                            slot_valid,
	output logic                            second_leg,
	output logic [mssr_pkg::TAG_W-1:0]      tag_out,
	output logic                            last_slot
);
	import mssr_pkg::*;

	// Captured request.
	dir_t               first_dir_q;
	logic [HOP_W-1:0]   h1_q;
	logic [HOP_W-1:0]   h2_q;
	logic [TAG_W-1:0]   tag_q;

	// Current leg.
	logic signed [X_W-1:0] lx_q;
	logic signed [Y_W-1:0] ly_q;
	dir_t                  dir_q;
	logic [HOP_W-1:0]      hop_q;
	logic                  leg2_q;

	// Slot register.
	logic                  out_valid_q;
	logic [ROUTER_W-1:0]   hop_router_q;
	dir_t                  arrival_q;
	logic [HOP_W-1:0]      hop_dist_q;
	logic                  bypass_q;
	logic                  slot_valid_q;
	logic                  second_leg_q;
	logic [TAG_W-1:0]      tag_out_q;
	logic                  last_q;

	// Divider results.
	logic [ROUTER_W-1:0] sy;
	logic [ROUTER_W-1:0] ey;
	logic [REM_W-1:0]    sx;
	logic [REM_W-1:0]    ex;
	logic                div_last;
	logic                dst_last;

	// Second-leg set-up and slot values.
	dir_t                  dir2;
	logic signed [X_W-1:0] lx2;
	logic signed [Y_W-1:0] ly2;
	logic signed [X_W-1:0] tx;
	logic signed [Y_W-1:0] ty;
	logic signed [X_W-1:0] hx;
	logic signed [Y_W-1:0] hy;
	logic                  in_mesh;
	logic [8:0]            id_full;
	logic [HOP_W-1:0]      leg_hops;
	logic                  out_free;

	// Column and row of source and destination, computed side by side.
	mssr_div u_src_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.load),
		.step      (cmd.div_step),
		.dividend  (source_router),
		.divisor   (mesh_cols),
		.quotient  (sy),
		.remainder (sx),
		.last      (div_last)
	);

	mssr_div u_dst_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.load),
		.step      (cmd.div_step),
		.dividend  (target_router_final),
		.divisor   (mesh_cols),
		.quotient  (ey),
		.remainder (ex),
		.last      (dst_last)
	);

	// The second leg starts at the turning router and heads for the destination.
	always_comb begin
		if (first_dir_q inside {DIR_EAST, DIR_WEST}) begin
			dir2 = (ey >= sy) ? DIR_NORTH : DIR_SOUTH;
			lx2  = X_W'(signed'({1'b0, ex}));
			ly2  = Y_W'(signed'({1'b0, sy}));
		end else begin
			dir2 = (ex >= sx) ? DIR_EAST : DIR_WEST;
			lx2  = X_W'(signed'({1'b0, sx}));
			ly2  = Y_W'(signed'({1'b0, ey}));
		end
	end

	// Target router of the current hop and its mesh bounds check.
	always_comb begin
		hx = X_W'(signed'({1'b0, hop_q}));
		hy = Y_W'(signed'({1'b0, hop_q}));
		tx = lx_q;
		ty = ly_q;
		case (dir_q)
			DIR_EAST:  tx = lx_q + hx;
			DIR_WEST:  tx = lx_q - hx;
			DIR_NORTH: ty = ly_q + hy;
			DIR_SOUTH: ty = ly_q - hy;
			default:   tx = lx_q;
		endcase
		in_mesh = (tx >= 0) && (tx < X_W'(signed'({1'b0, mesh_cols})))
			&& (ty >= 0) && (ty < Y_W'(signed'({1'b0, mesh_rows})));
		// Inside the mesh both coordinates are below sixteen, so the id fits a byte.
		id_full  = ({5'b0, ty[REM_W-1:0]} * {4'b0, mesh_cols}) + {5'b0, tx[REM_W-1:0]};
		leg_hops = leg2_q ? h2_q : h1_q;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.div_last  = div_last && dst_last;
		sts.both_zero = (h1_q == '0) && (h2_q == '0);
		sts.h1_zero   = (h1_q == '0);
		sts.h2_zero   = (h2_q == '0);
		sts.leg_end   = (hop_q == leg_hops);
		sts.out_free  = out_free;
	end

	// Request capture and leg walk.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_dir_q <= dir_t'(first_direction);
			h1_q        <= sat_hops(first_hops);
			h2_q        <= sat_hops(second_hops);
			tag_q       <= request_tag;
		end
		if (cmd.leg2_start) begin
			lx_q   <= lx2;
			ly_q   <= ly2;
			dir_q  <= dir2;
			hop_q  <= HOP_W'(1);
			leg2_q <= 1'b1;
		end else if (cmd.leg1_start) begin
			lx_q   <= X_W'(signed'({1'b0, sx}));
			ly_q   <= Y_W'(signed'({1'b0, sy}));
			dir_q  <= first_dir_q;
			hop_q  <= HOP_W'(1);
			leg2_q <= 1'b0;
		end else if (cmd.emit) begin
			hop_q <= hop_q + HOP_W'(1);
		end
	end

	// Slot register: holds its beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_none) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_none) begin
			hop_router_q <= '0;
			arrival_q    <= DIR_EAST;
			hop_dist_q   <= '0;
			bypass_q     <= 1'b0;
			slot_valid_q <= 1'b0;
			second_leg_q <= 1'b0;
			tag_out_q    <= tag_q;
			last_q       <= 1'b1;
		end else if (cmd.emit) begin
			hop_router_q <= in_mesh ? id_full[ROUTER_W-1:0] : '0;
			arrival_q    <= opposite_dir(dir_q);
			hop_dist_q   <= hop_q;
			bypass_q     <= (hop_q != leg_hops);
			slot_valid_q <= in_mesh;
			second_leg_q <= leg2_q;
			tag_out_q    <= tag_q;
			last_q       <= cmd.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign hop_router     = hop_router_q;
	assign arrival_port   = arrival_q;
	assign hop_distance   = hop_dist_q;
	assign bypass_request = bypass_q;
	assign slot_valid     = slot_valid_q;
	assign second_leg     = second_leg_q;
	assign tag_out        = tag_out_q;
	assign last_slot      = last_q;

`ifndef ASSERT_OFF
	// A slot inside the mesh always belongs to a real hop.
	a_valid_slot_has_hop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && slot_valid_q |-> hop_dist_q != '0)
		else $error("valid slot with zero hop distance");
`endif

endmodule

[rtl/mssr_ctrl.sv]
// Controller state machine of the fan-out: request intake, division, both legs and empty slot.
// Depends on mssr_pkg.
module mssr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  mssr_pkg::sts_t sts,
	output mssr_pkg::cmd_t cmd
);
	import mssr_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (sts.both_zero) begin
					state_d = ST_NONE;
				end else if (!sts.h1_zero) begin
					cmd.leg1_start = 1'b1;
					state_d        = ST_LEG1;
				end else begin
					cmd.leg2_start = 1'b1;
					state_d        = ST_LEG2;
				end
			end
			ST_NONE: begin
				if (sts.out_free) begin
					cmd.emit_none = 1'b1;
					cmd.last      = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_LEG1: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.leg_end) begin
						if (sts.h2_zero) begin
							cmd.last = 1'b1;
							state_d  = ST_IDLE;
						end else begin
							cmd.leg2_start = 1'b1;
							state_d        = ST_LEG2;
						end
					end
				end
			end
			ST_LEG2: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.leg_end) begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// A slot is only loaded when the slot register can take it.
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_none) |-> sts.out_free)
		else $error("slot loaded over an untaken beat");

	// An accepted request always starts the division.
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_DIV)
		else $error("accepted request did not start division");

	// The last slot of a request returns the controller to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit || cmd.emit_none) && cmd.last) |=> state_q == ST_IDLE)
		else $error("last slot did not end the request");
`endif

endmodule

[rtl/mesh_ssr_fanout_top.sv]
// Top level of the mesh bypass-request fan-out: configuration registers and wiring.
// Depends on mssr_pkg, mssr_ctrl and mssr_dp.
//
// Usage:
//   Request channel: in_valid/in_stall with source_router, target_router_final,
//   first_direction, first_hops, second_hops and request_tag. A beat is taken
//   when in_valid is high and in_stall is low; in_stall is low only while idle.
//   Slot channel: out_valid/out_stall; one beat per hop, first leg then second
//   leg, last_slot marking the final beat of a request. A request with no hops
//   gives a single beat with slot_valid low and last_slot high.
//   Configuration: cfg_valid/cfg_ready, cfg_index 0 for mesh_columns and 1 for
//   mesh_rows; other indexes are ignored. cfg_ready is always high.
// Timing:
//   After a request beat the source and destination coordinates are found by
//   an 8-step restoring divider, then a set-up step, then one slot per cycle while
//   the slot channel does not stall; a request gives n slots, n from 1 to 16.
//   A stall on the slot channel holds the current beat and pauses the leg walk.
// Reset:
//   Both mesh dimensions return to 4 and the controller to idle; no slot is
//   pending after reset.
module mesh_ssr_fanout_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mssr_pkg::ROUTER_W-1:0]     source_router,
	input  logic [mssr_pkg::ROUTER_W-1:0]     target_router_final,
	input  logic [mssr_pkg::DIR_W-1:0]        first_direction,
	input  logic [mssr_pkg::HOP_W-1:0]        first_hops,
	input  logic [mssr_pkg::HOP_W-1:0]        second_hops,
	input  logic [mssr_pkg::TAG_W-1:0]        request_tag,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mssr_pkg::ROUTER_W-1:0]     hop_router,
	output logic [mssr_pkg::DIR_W-1:0]        arrival_port,
	output logic [mssr_pkg::HOP_W-1:0]        hop_distance,
	output logic                              bypass_request,
	output logic                              slot_valid,
	output logic                              second_leg,
	output logic [mssr_pkg::TAG_W-1:0]        tag_out,
	output logic                              last_slot,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mssr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mssr_pkg::DIM_W-1:0]        cfg_data
);
	import mssr_pkg::*;

	logic [DIM_W-1:0] cols_raw_q;
	logic [DIM_W-1:0] rows_raw_q;
	logic [DIM_W-1:0] mesh_cols;
	logic [DIM_W-1:0] mesh_rows;
	cmd_t             cmd;
	sts_t             sts;

	assign cfg_ready = 1'b1;

	// Configuration registers, written a beat at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_raw_q <= DIM_RESET;
			rows_raw_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MESH_COLUMNS: cols_raw_q <= cfg_data;
				CFG_MESH_ROWS:    rows_raw_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Out-of-range dimensions are pulled into 1..16.
	assign mesh_cols = clamp_dim(cols_raw_q);
	assign mesh_rows = clamp_dim(rows_raw_q);

	mssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mssr_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.mesh_cols           (mesh_cols),
		.mesh_rows           (mesh_rows),
		.source_router       (source_router),
		.target_router_final (target_router_final),
		.first_direction     (first_direction),
		.first_hops          (first_hops),
		.second_hops         (second_hops),
		.request_tag         (request_tag),
		.out_stall           (out_stall),
		.out_valid           (out_valid),
		.hop_router          (hop_router),
		.arrival_port        (arrival_port),
		.hop_distance        (hop_distance),
		.bypass_request      (bypass_request),
		.slot_valid          (slot_valid),
		.second_leg          (second_leg),
		.tag_out             (tag_out),
		.last_slot           (last_slot)
	);

endmodule

[bench/tb_mesh_ssr_fanout_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for mesh_ssr_fanout_top: queued request driver, slot monitor, predictor.
// Depends on mssr_pkg and the RTL of the block; reads no files.
module tb_mesh_ssr_fanout_top;
	import mssr_pkg::*;

	localparam int MAX_SLOTS     = 16;
	localparam int DIM_LIMIT     = 16;
	localparam int ROUTER_LIMIT  = 1 << ROUTER_W;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;
	localparam int REPORT_LIMIT  = 10;

	// Register indexes that the block must ignore.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

	typedef enum int {
		PACE_STEADY,
		PACE_SENDER_GAPS,
		PACE_RECEIVER_STALLS,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic [ROUTER_W-1:0] src;
		logic [ROUTER_W-1:0] dst;
		dir_t                dir;
		logic [HOP_W-1:0]    first_hops;
		logic [HOP_W-1:0]    second_hops;
		logic [TAG_W-1:0]    tag;
	} request_t;

	typedef struct packed {
		logic [ROUTER_W-1:0] hop_router;
		logic [DIR_W-1:0]    arrival_port;
		logic [HOP_W-1:0]    hop_distance;
		logic                bypass_request;
		logic                slot_valid;
		logic                second_leg;
		logic [TAG_W-1:0]    tag_out;
		logic                last_slot;
	} slot_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid            = 1'b0;
	logic                 in_stall;
	logic [ROUTER_W-1:0]  source_router       = '0;
	logic [ROUTER_W-1:0]  target_router_final = '0;
	logic [DIR_W-1:0]     first_direction     = '0;
	logic [HOP_W-1:0]     first_hops          = '0;
	logic [HOP_W-1:0]     second_hops         = '0;
	logic [TAG_W-1:0]     request_tag         = '0;
	logic                 out_valid;
	logic                 out_stall           = 1'b0;
	logic [ROUTER_W-1:0]  hop_router;
	logic [DIR_W-1:0]     arrival_port;
	logic [HOP_W-1:0]     hop_distance;
	logic                 bypass_request;
	logic                 slot_valid;
	logic                 second_leg;
	logic [TAG_W-1:0]     tag_out;
	logic                 last_slot;
	logic                 cfg_valid           = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index           = '0;
	logic [DIM_W-1:0]     cfg_data            = '0;

	// Bench copy of the mesh dimension registers.
	logic [DIM_W-1:0] mesh_cols_reg = DIM_RESET;
	logic [DIM_W-1:0] mesh_rows_reg = DIM_RESET;

	request_t pending_requests[$];
	slot_t    expected_slots[$];
	request_t send_beat;
	request_t taken_beat;
	slot_t    fan_slots[MAX_SLOTS];
	int       fan_count;
	slot_t    seen_slot;
	slot_t    want_slot;

	pace_t pace         = PACE_STEADY;
	int    req_sent     = 0;
	int    req_taken    = 0;
	int    slots_seen   = 0;
	int    cfg_writes   = 0;
	int    phases_run   = 0;
	int    fault_count  = 0;
	int    quiet_cycles = 0;
	int    hold_kicks   = 0;
	int    hold_seen    = 0;
	int    hold_left    = 0;
	bit    progress;

	mesh_ssr_fanout_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.source_router       (source_router),
		.target_router_final (target_router_final),
		.first_direction     (first_direction),
		.first_hops          (first_hops),
		.second_hops         (second_hops),
		.request_tag         (request_tag),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.hop_router          (hop_router),
		.arrival_port        (arrival_port),
		.hop_distance        (hop_distance),
		.bypass_request      (bypass_request),
		.slot_valid          (slot_valid),
		.second_leg          (second_leg),
		.tag_out             (tag_out),
		.last_slot           (last_slot),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A mesh dimension of zero behaves as one, anything above sixteen as sixteen.
	function automatic int dim_eff(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > DIM_LIMIT) begin
			return DIM_LIMIT;
		end
		return int'(v);
	endfunction

	// Walk one leg from its start router and append a slot per hop.
	function automatic void walk_leg(inout slot_t res[MAX_SLOTS], inout int n,
			input int cols, input int rows, input int sx, input int sy,
			input dir_t d, input int hops, input logic leg2, input logic [TAG_W-1:0] tag);
		int   dx;
		int   dy;
		int   tx;
		int   ty;
		int   id;
		bit   in_mesh;
		dir_t back;
		dx = (d == DIR_EAST) ? 1 : (d == DIR_WEST) ? -1 : 0;
		dy = (d == DIR_NORTH) ? 1 : (d == DIR_SOUTH) ? -1 : 0;
		case (d)
			DIR_EAST: begin
				back = DIR_WEST;
			end
			DIR_WEST: begin
				back = DIR_EAST;
			end
			DIR_NORTH: begin
				back = DIR_SOUTH;
			end
			default: begin
				back = DIR_NORTH;
			end
		endcase
		for (int h = 1; h <= hops; h++) begin
			tx = sx + dx * h;
			ty = sy + dy * h;
			in_mesh = (tx >= 0) && (tx < cols) && (ty >= 0) && (ty < rows);
			id = in_mesh ? ty * cols + tx : 0;
			if (id >= ROUTER_LIMIT) begin
				in_mesh = 1'b0;
				id = 0;
			end
			res[n].hop_router     = ROUTER_W'(id);
			res[n].arrival_port   = back;
			res[n].hop_distance   = HOP_W'(h);
			res[n].bypass_request = (h != hops);
			res[n].slot_valid     = in_mesh;
			res[n].second_leg     = leg2;
			res[n].tag_out        = tag;
			res[n].last_slot      = 1'b0;
			n++;
		end
	endfunction

	// Expected slots of one request under the current mesh dimensions.
	function automatic void predict_fanout(input request_t r, output slot_t res[MAX_SLOTS],
			output int n);
		int   cols;
		int   rows;
		int   sx;
		int   sy;
		int   ex;
		int   ey;
		int   h1;
		int   h2;
		int   tx;
		int   ty;
		dir_t d2;
		cols = dim_eff(mesh_cols_reg);
		rows = dim_eff(mesh_rows_reg);
		sx = int'(r.src) % cols;
		sy = int'(r.src) / cols;
		ex = int'(r.dst) % cols;
		ey = int'(r.dst) / cols;
		h1 = (r.first_hops > MAX_HOPS) ? int'(MAX_HOPS) : int'(r.first_hops);
		h2 = (r.second_hops > MAX_HOPS) ? int'(MAX_HOPS) : int'(r.second_hops);
		n = 0;
		if (h1 == 0 && h2 == 0) begin
			res[0] = '0;
			res[0].tag_out = r.tag;
			res[0].last_slot = 1'b1;
			n = 1;
			return;
		end
		walk_leg(res, n, cols, rows, sx, sy, r.dir, h1, 1'b0, r.tag);
		if (h2 > 0) begin
			// The turning router lies in the destination's column after an east or west leg, else in its row.
			if (r.dir == DIR_EAST || r.dir == DIR_WEST) begin
				d2 = (ey >= sy) ? DIR_NORTH : DIR_SOUTH;
				tx = ex;
				ty = sy;
			end else begin
				d2 = (ex >= sx) ? DIR_EAST : DIR_WEST;
				tx = sx;
				ty = ey;
			end
			walk_leg(res, n, cols, rows, tx, ty, d2, h2, 1'b1, r.tag);
		end
		res[n-1].last_slot = 1'b1;
	endfunction

	function automatic string slot_text(input slot_t s);
		return $sformatf("router=%0d port=%0d dist=%0d bypass=%0b valid=%0b leg2=%0b tag=%h last=%0b",
			s.hop_router, s.arrival_port, s.hop_distance, s.bypass_request, s.slot_valid,
			s.second_leg, s.tag_out, s.last_slot);
	endfunction

	task automatic log_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%s", what);
		end
	endtask

	// Request driver: a new beat goes out at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && req_sent == req_taken) begin
			if (pending_requests.size() != 0 &&
					!((pace == PACE_SENDER_GAPS && $urandom_range(99) < 59) ||
					(pace == PACE_BOTH && $urandom_range(99) < 20))) begin
				send_beat = pending_requests.pop_front();
				in_valid            <= 1'b1;
				source_router       <= send_beat.src;
				target_router_final <= send_beat.dst;
				first_direction     <= send_beat.dir;
				first_hops          <= send_beat.first_hops;
				second_hops         <= send_beat.second_hops;
				request_tag         <= send_beat.tag;
				req_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Slot receiver: random stalls, plus a long hold-off counted here when requested.
	always @(negedge clk) begin
		if (hold_seen != hold_kicks) begin
			hold_seen = hold_kicks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (pace == PACE_RECEIVER_STALLS) begin
			out_stall <= ($urandom_range(99) < 59);
		end else if (pace == PACE_BOTH) begin
			out_stall <= ($urandom_range(99) < 20);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: check slot beats, predict for taken requests, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				seen_slot.hop_router     = hop_router;
				seen_slot.arrival_port   = arrival_port;
				seen_slot.hop_distance   = hop_distance;
				seen_slot.bypass_request = bypass_request;
				seen_slot.slot_valid     = slot_valid;
				seen_slot.second_leg     = second_leg;
				seen_slot.tag_out        = tag_out;
				seen_slot.last_slot      = last_slot;
				if (expected_slots.size() == 0) begin
					log_fault($sformatf("Unexpected slot: %s", slot_text(seen_slot)));
				end else begin
					want_slot = expected_slots.pop_front();
					slots_seen++;
					if (seen_slot !== want_slot) begin
						log_fault($sformatf("Slot mismatch: expected %s, got %s",
							slot_text(want_slot), slot_text(seen_slot)));
					end
				end
			end
			if (in_valid && !in_stall) begin
				progress = 1'b1;
				req_taken++;
				taken_beat.src         = source_router;
				taken_beat.dst         = target_router_final;
				taken_beat.dir         = dir_t'(first_direction);
				taken_beat.first_hops  = first_hops;
				taken_beat.second_hops = second_hops;
				taken_beat.tag         = request_tag;
				predict_fanout(taken_beat, fan_slots, fan_count);
				for (int i = 0; i < fan_count; i++) begin
					expected_slots = {expected_slots, fan_slots[i]};
				end
			end
			if (cfg_valid && cfg_ready) begin
				progress = 1'b1;
			end
			quiet_cycles = progress ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("tb_mesh_ssr_fanout_top NOT OK");
				$finish;
			end
		end
	end

	task automatic queue_request(input int src, input int dst, input dir_t d, input int h1,
			input int h2, input int tag);
		request_t r;
		r.src         = ROUTER_W'(src);
		r.dst         = ROUTER_W'(dst);
		r.dir         = d;
		r.first_hops  = HOP_W'(h1);
		r.second_hops = HOP_W'(h2);
		r.tag         = TAG_W'(tag);
		pending_requests = {pending_requests, r};
	endtask

	// Register write beat; the bench copy follows the same index decoding.
	task automatic write_mesh_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx == CFG_MESH_COLUMNS) begin
			mesh_cols_reg = val;
		end else if (idx == CFG_MESH_ROWS) begin
			mesh_rows_reg = val;
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every request is taken and every slot has come, then let the block settle.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || req_sent != req_taken ||
				expected_slots.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random phase: set the mesh, pick the pace, queue requests and drain.
	task automatic run_phase(input logic [DIM_W-1:0] cols_val, input logic [DIM_W-1:0] rows_val,
			input pace_t p, input int count, input bit squeeze);
		int span;
		int src;
		int dst;
		int h1;
		int h2;
		write_mesh_reg(CFG_MESH_COLUMNS, cols_val);
		write_mesh_reg(CFG_MESH_ROWS, rows_val);
		write_mesh_reg(($urandom_range(1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
			DIM_W'($urandom_range(31)));
		pace = p;
		if (squeeze) begin
			hold_kicks++;
		end
		span = dim_eff(mesh_cols_reg) * dim_eff(mesh_rows_reg);
		for (int i = 0; i < count; i++) begin
			// Mostly routers inside the mesh with mostly in-range legs; the rest is anything.
			if ($urandom_range(99) < 75) begin
				src = $urandom_range(span - 1);
				dst = $urandom_range(span - 1);
				h1 = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
				h2 = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
			end else begin
				src = $urandom_range(ROUTER_LIMIT - 1);
				dst = $urandom_range(ROUTER_LIMIT - 1);
				h1 = $urandom_range(15);
				h2 = $urandom_range(15);
			end
			queue_request(src, dst, dir_t'($urandom_range(3)), h1, h2, $urandom_range(65535));
		end
		wait_drained();
		phases_run++;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests on the reset mesh of four by four.
		queue_request(0, 0, DIR_EAST, 0, 0, 16'hFFFF);
		queue_request(5, 15, DIR_EAST, 0, 3, 16'h0000);
		queue_request(0, 15, DIR_EAST, 3, 3, 16'h1234);
		queue_request(12, 3, DIR_EAST, 2, 2, 16'hA5A5);
		queue_request(3, 0, DIR_WEST, 3, 0, 16'h0F0F);
		queue_request(0, 5, DIR_WEST, 2, 1, 16'hF0F0);
		queue_request(12, 0, DIR_SOUTH, 3, 2, 16'h8001);
		queue_request(1, 12, DIR_SOUTH, 1, 1, 16'h7FFE);
		queue_request(0, 15, DIR_NORTH, 4, 4, 16'h00FF);
		queue_request(7, 4, DIR_NORTH, 2, 2, 16'hFF00);
		queue_request(0, 255, DIR_EAST, 15, 15, 16'hFFFF);
		queue_request(255, 255, DIR_WEST, 8, 8, 16'h3C3C);
		queue_request(0, 0, DIR_NORTH, 9, 0, 16'hC3C3);
		queue_request(10, 10, DIR_SOUTH, 0, 12, 16'h1111);
		queue_request(6, 9, DIR_EAST, 1, 1, 16'h2222);
		queue_request(15, 0, DIR_WEST, 8, 8, 16'h5A5A);
		queue_request(200, 17, DIR_SOUTH, 5, 3, 16'h4444);
		queue_request(0, 0, DIR_EAST, 0, 0, 16'h0000);
		wait_drained();
		phases_run++;

		// Random phases across mesh shapes, out-of-range register values and pacing.
		run_phase(5'd16, 5'd16, PACE_STEADY, 45, 1'b0);
		run_phase(5'd1, 5'd1, PACE_SENDER_GAPS, 45, 1'b0);
		run_phase(5'd0, 5'd31, PACE_RECEIVER_STALLS, 45, 1'b0);
		run_phase(5'd31, 5'd0, PACE_BOTH, 45, 1'b0);
		run_phase(5'd16, 5'd16, PACE_STEADY, 30, 1'b1);
		run_phase(5'd5, 5'd7, PACE_SENDER_GAPS, 45, 1'b0);
		run_phase(DIM_W'($urandom_range(31)), DIM_W'($urandom_range(31)),
			PACE_RECEIVER_STALLS, 45, 1'b0);
		run_phase(DIM_W'($urandom_range(31)), DIM_W'($urandom_range(31)), PACE_BOTH, 45, 1'b0);
		run_phase(5'd8, 5'd3, PACE_STEADY, 15, 1'b0);

		$display("Ran %0d requests in %0d phases; %0d slots checked after %0d register writes.",
			req_taken, phases_run, slots_seen, cfg_writes);
		$display("Pacing covered steady flow, sender gaps, receiver stalls and a long hold-off.");
		if (fault_count == 0) begin
			$display("tb_mesh_ssr_fanout_top OK");
		end else begin
			$display("%0d faults found", fault_count);
			$display("tb_mesh_ssr_fanout_top NOT OK");
		end
		$finish;
	end

endmodule

[mesh_ssr_fanout_top.f]
rtl/mssr_pkg.sv
rtl/mssr_div.sv
rtl/mssr_dp.sv
rtl/mssr_ctrl.sv
rtl/mesh_ssr_fanout_top.sv
bench/tb_mesh_ssr_fanout_top.sv
